FILE: design/lasc_pkg.sv
// Shared types, constants and the sine/cosine table generator for the lidar
// clearance core. No dependencies.
package lasc_pkg;

	localparam int ANGLE_W    = 16;
	localparam int RANGE_IN_W = 16;
	localparam int ROOM_W     = 16;
	localparam int OCT_W      = 13;
	localparam int OCT_DEPTH  = 4501;
	localparam int TRIG_MAX_W = 18;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [ANGLE_W-1:0] ANGLE_FULL   = 16'd36000;
	localparam logic [ANGLE_W-1:0] ANGLE_Q3     = 16'd27000;
	localparam logic [ANGLE_W-1:0] ANGLE_Q2     = 16'd18000;
	localparam logic [ANGLE_W-1:0] ANGLE_Q1     = 16'd9000;
	localparam logic [ANGLE_W-1:0] ANGLE_OCTANT = 16'd4500;

	localparam logic [RANGE_IN_W-1:0] MIN_RANGE_MM = 16'd30;
	localparam logic signed [ROOM_W-1:0] ROOM_START = 16'sd9900;
	localparam logic signed [ROOM_W-1:0] ROOM_FLOOR = -16'sd2047;

	localparam logic [63:0] ONE_Q30          = 64'd1 << 30;
	localparam logic [63:0] RAD_PER_CDEG_Q30 = 64'd187403;

	typedef enum logic [1:0] {
		REG_REVERSE     = 2'd0,
		REG_HALF_LENGTH = 2'd1,
		REG_HALF_WIDTH  = 2'd2,
		REG_SIDE_MARGIN = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic        reverse_direction;
		logic [10:0] half_length_mm;
		logic [10:0] half_width_mm;
		logic [9:0]  side_margin_mm;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic keep;
		logic last;
	} item_ctl_t;

	typedef struct packed {
		logic sn_neg;
		logic cs_neg;
	} trig_sign_t;

	typedef struct packed {
		logic                     push;
		logic signed [ROOM_W-1:0] data;
	} result_push_t;

	// Sine and cosine of t centidegrees (t up to one octant), each rounded
	// to frac fractional bits; sine in the upper half of the result.
	function automatic logic [2*TRIG_MAX_W-1:0] octant_trig(input logic [OCT_W-1:0] t,
			input int frac);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] h;
		logic [63:0] s;
		logic [63:0] c;
		x  = 64'(t) * RAD_PER_CDEG_Q30;
		x2 = (x * x) >> 30;

		h = ONE_Q30 - x2 / 64'd42;
		h = ONE_Q30 - ((x2 * h) >> 30) / 64'd20;
		h = ONE_Q30 - ((x2 * h) >> 30) / 64'd6;
		s = (x * h) >> 30;
		s = (s + (64'd1 << (29 - frac))) >> (30 - frac);

		h = ONE_Q30 - x2 / 64'd56;
		h = ONE_Q30 - ((x2 * h) >> 30) / 64'd30;
		h = ONE_Q30 - ((x2 * h) >> 30) / 64'd12;
		c = ONE_Q30 - ((x2 * h) >> 30) / 64'd2;
		c = (c + (64'd1 << (29 - frac))) >> (30 - frac);

		return {s[TRIG_MAX_W-1:0], c[TRIG_MAX_W-1:0]};
	endfunction

endpackage

FILE: design/lasc_ifs.sv
// Valid/ready channel interfaces for lidar readings and clearance results.
// Depends on lasc_pkg.
interface lasc_in_if;
	import lasc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [RANGE_IN_W-1:0] range_mm;
	logic [ANGLE_W-1:0]    angle_cdeg;
	logic                  scan_end;

	modport source (output valid, output range_mm, output angle_cdeg, output scan_end,
		input ready);
	modport sink (input valid, input range_mm, input angle_cdeg, input scan_end,
		output ready);
endinterface

interface lasc_out_if;
	import lasc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [ROOM_W-1:0] free_distance_mm;

	modport source (output valid, output free_distance_mm, input ready);
	modport sink (input valid, input free_distance_mm, output ready);
endinterface

FILE: design/lasc_cfg.sv
// APB-style configuration registers of the lidar clearance core.
// Depends on lasc_pkg.
module lasc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lasc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [lasc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [lasc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                             pready,
	output lasc_pkg::cfg_t                   cfg
);
	import lasc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reverse_direction <= 1'b0;
			cfg_q.half_length_mm    <= 11'd100;
			cfg_q.half_width_mm     <= 11'd65;
			cfg_q.side_margin_mm    <= 10'd10;
		end else if (wr_en) begin
			unique case (idx)
				REG_REVERSE:     cfg_q.reverse_direction <= pwdata[0];
				REG_HALF_LENGTH: cfg_q.half_length_mm    <= pwdata[10:0];
				REG_HALF_WIDTH:  cfg_q.half_width_mm     <= pwdata[10:0];
				REG_SIDE_MARGIN: cfg_q.side_margin_mm    <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_REVERSE:     prdata = CFG_DATA_W'(cfg_q.reverse_direction);
			REG_HALF_LENGTH: prdata = CFG_DATA_W'(cfg_q.half_length_mm);
			REG_HALF_WIDTH:  prdata = CFG_DATA_W'(cfg_q.half_width_mm);
			REG_SIDE_MARGIN: prdata = CFG_DATA_W'(cfg_q.side_margin_mm);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: design/lasc_trig.sv
// Angle reduction and sine/cosine lookup from an octant ROM, one registered
// stage. Depends on lasc_pkg.
module lasc_trig #(
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                          clk,
	input  logic [lasc_pkg::ANGLE_W-1:0]  angle_s1,
	output logic [TRIG_FRAC_BITS:0]       sn_mag_s2,
	output logic [TRIG_FRAC_BITS:0]       cs_mag_s2,
	output lasc_pkg::trig_sign_t          sign_s2
);
	import lasc_pkg::*;

	localparam int TW = TRIG_FRAC_BITS + 1;

	logic [2*TW-1:0]    rom [OCT_DEPTH];
	logic [ANGLE_W-1:0] a_mod;
	logic [ANGLE_W-1:0] r;
	logic [1:0]         quad;
	logic               swap;
	logic [OCT_W-1:0]   t;
	logic [2*TW-1:0]    entry_s2;
	logic [1:0]         quad_s2;
	logic               swap_s2;
	logic [TW-1:0]      ts;
	logic [TW-1:0]      tc;
	logic               sel;

	for (genvar g = 0; g < OCT_DEPTH; g++) begin : g_rom
		localparam logic [2*TRIG_MAX_W-1:0] ENTRY = octant_trig(OCT_W'(g), TRIG_FRAC_BITS);
		assign rom[g] = {ENTRY[TRIG_MAX_W +: TW], ENTRY[0 +: TW]};
	end

	always_comb begin
		a_mod = (angle_s1 >= ANGLE_FULL) ? angle_s1 - ANGLE_FULL : angle_s1;
		if (a_mod >= ANGLE_Q3) begin
			quad = 2'd3;
			r    = a_mod - ANGLE_Q3;
		end else if (a_mod >= ANGLE_Q2) begin
			quad = 2'd2;
			r    = a_mod - ANGLE_Q2;
		end else if (a_mod >= ANGLE_Q1) begin
			quad = 2'd1;
			r    = a_mod - ANGLE_Q1;
		end else begin
			quad = 2'd0;
			r    = a_mod;
		end
		swap = r > ANGLE_OCTANT;
		t    = swap ? OCT_W'(ANGLE_Q1 - r) : OCT_W'(r);
	end

	always_ff @(posedge clk) begin
		entry_s2 <= rom[t];
		quad_s2  <= quad;
		swap_s2  <= swap;
	end

	assign ts  = entry_s2[TW +: TW];
	assign tc  = entry_s2[0 +: TW];
	assign sel = swap_s2 ^ quad_s2[0];

	assign sn_mag_s2      = sel ? tc : ts;
	assign cs_mag_s2      = sel ? ts : tc;
	assign sign_s2.sn_neg = quad_s2[1];
	assign sign_s2.cs_neg = quad_s2[1] ^ quad_s2[0];

endmodule

FILE: design/lasc_track.sv
// Coordinate products, sweep band test and running minimum of the free
// distance per scan. Depends on lasc_pkg.
module lasc_track #(
	parameter int RANGE_BITS     = 16,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lasc_pkg::cfg_t            cfg,
	input  lasc_pkg::item_ctl_t       ctl_s2,
	input  logic [RANGE_BITS-1:0]     range_s2,
	input  logic [TRIG_FRAC_BITS:0]   sn_mag_s2,
	input  logic [TRIG_FRAC_BITS:0]   cs_mag_s2,
	input  lasc_pkg::trig_sign_t      sign_s2,
	output lasc_pkg::result_push_t    res
);
	import lasc_pkg::*;

	localparam int TW = TRIG_FRAC_BITS + 1;
	localparam int PW = RANGE_BITS + TW;
	localparam int CW = PW + 12;
	localparam int AW = PW + 1 - TRIG_FRAC_BITS;
	localparam int RW = AW + 1;
	localparam int MW = (RW > ROOM_W) ? RW : ROOM_W;

	item_ctl_t                ctl_s3;
	logic                     ok_s3;
	logic [PW-1:0]            py_s3;
	logic [PW-1:0]            along_s3;
	logic signed [ROOM_W-1:0] nearest_q;

	logic [11:0]              band;
	logic                     band_ok;
	logic [PW:0]              along_rnd;
	logic [AW-1:0]            along_mm;
	logic signed [RW-1:0]     room;
	logic signed [MW-1:0]     room_x;
	logic signed [MW-1:0]     nearest_x;
	logic                     hit;
	logic signed [ROOM_W-1:0] min_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		py_s3    <= PW'(range_s2) * PW'(sn_mag_s2);
		along_s3 <= PW'(range_s2) * PW'(cs_mag_s2);
		ok_s3    <= sign_s2.cs_neg == cfg.reverse_direction;
	end

	always_comb begin
		band      = 12'(cfg.half_width_mm) + 12'(cfg.side_margin_mm);
		band_ok   = CW'(py_s3) <= CW'({band, {TRIG_FRAC_BITS{1'b0}}});
		along_rnd = (PW+1)'(along_s3) + ((PW+1)'(1) << (TRIG_FRAC_BITS - 1));
		along_mm  = along_rnd[PW:TRIG_FRAC_BITS];
		room      = $signed({1'b0, along_mm}) - $signed(RW'(cfg.half_length_mm));
		room_x    = MW'(room);
		nearest_x = MW'(nearest_q);
		hit       = ctl_s3.keep && ok_s3 && (along_s3 != '0) && band_ok;
		min_val   = (hit && room_x < nearest_x) ? ROOM_W'(room) : nearest_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nearest_q <= ROOM_START;
		end else if (ctl_s3.valid) begin
			nearest_q <= ctl_s3.last ? ROOM_START : min_val;
		end
	end

	assign res.push = ctl_s3.valid && ctl_s3.last;
	assign res.data = min_val;

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid && ctl_s3.last |=> nearest_q == ROOM_START)
		else $error("running minimum not restarted after a scan end");
	a_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		nearest_q <= ROOM_START)
		else $error("running minimum above its start value");
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		res.push |-> (res.data <= ROOM_START && res.data >= ROOM_FLOOR))
		else $error("scan result outside its possible range");

endmodule

FILE: design/lasc_oq.sv
// Result queue that holds finished scan results until the consumer takes
// them. Depends on lasc_pkg and lasc_ifs.
module lasc_oq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lasc_pkg::result_push_t        res,
	output logic [lasc_pkg::QCNT_W-1:0]   count,
	lasc_out_if.source                    out_ch
);
	import lasc_pkg::*;

	logic signed [ROOM_W-1:0] mem [QDEPTH];
	logic [QPTR_W-1:0]        wr_ptr_q;
	logic [QPTR_W-1:0]        rd_ptr_q;
	logic [QCNT_W-1:0]        count_q;
	logic                     pop;

	assign pop                    = out_ch.valid && out_ch.ready;
	assign out_ch.valid           = count_q != '0;
	assign out_ch.free_distance_mm = mem[rd_ptr_q];
	assign count                  = count_q;

	always_ff @(posedge clk) begin
		if (res.push) begin
			mem[wr_ptr_q] <= res.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (res.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (res.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !res.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res.push |-> count_q < QCNT_W'(QDEPTH))
		else $error("result queue written while full");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		res.push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("result queue count not raised on a write");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !res.push |=> count_q == $past(count_q) - 1'b1)
		else $error("result queue count not lowered on a transfer");

endmodule

FILE: design/lidar_axis_sweep_clearance_core.sv
// Lidar sweep clearance core: one reading per ready clock cycle in, one free
// distance per scan out. Depends on lasc_pkg, lasc_ifs and the lasc modules.
//
// The core takes one lidar reading in every clock cycle while input ready is
// high, also while results wait to be taken. A reading goes through three
// registers: the input register, the sine/cosine ROM (one octant, 4501
// entries, one read per cycle) and the coordinate product register, after
// which it updates the running minimum and, for the final reading of a scan,
// pushes the free distance of the scan into a four-entry result queue. Input
// ready drops only while queued results plus final readings still in the
// pipeline reach four. A consumer that is always ready therefore slows the
// reading stream only when four readings taken in consecutive cycles each end
// a scan, as when every reading ends a scan.
module lidar_axis_sweep_clearance_core #(
	parameter int RANGE_BITS     = 16,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lasc_in_if.sink                          reading,
	lasc_out_if.source                       clearance,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lasc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [lasc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [lasc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                             pready
);
	import lasc_pkg::*;

	cfg_t                      cfg;
	logic                      accept;
	logic                      valid_s1;
	logic                      last_s1;
	logic [RANGE_BITS-1:0]     range_s1;
	logic [ANGLE_W-1:0]        angle_s1;
	item_ctl_t                 ctl_s2;
	logic [RANGE_BITS-1:0]     range_s2;
	logic [TRIG_FRAC_BITS:0]   sn_mag_s2;
	logic [TRIG_FRAC_BITS:0]   cs_mag_s2;
	trig_sign_t                sign_s2;
	result_push_t              res;
	logic [QCNT_W-1:0]         q_count;
	logic [QCNT_W:0]           pending;

	lasc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign pending = (QCNT_W+1)'(q_count)
		+ (QCNT_W+1)'(valid_s1 && last_s1)
		+ (QCNT_W+1)'(ctl_s2.valid && ctl_s2.last)
		+ (QCNT_W+1)'(res.push);
	assign reading.ready = pending < (QCNT_W+1)'(QDEPTH);
	assign accept        = reading.valid && reading.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s2   <= '0;
		end else begin
			valid_s1     <= accept;
			ctl_s2.valid <= valid_s1;
			ctl_s2.last  <= valid_s1 && last_s1;
			ctl_s2.keep  <= RANGE_IN_W'(range_s1) > MIN_RANGE_MM || RANGE_BITS > RANGE_IN_W
				&& range_s1 > RANGE_BITS'(MIN_RANGE_MM);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			range_s1 <= RANGE_BITS'(reading.range_mm);
			angle_s1 <= reading.angle_cdeg;
			last_s1  <= reading.scan_end;
		end
		range_s2 <= range_s1;
	end

	lasc_trig #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_trig (
		.clk       (clk),
		.angle_s1  (angle_s1),
		.sn_mag_s2 (sn_mag_s2),
		.cs_mag_s2 (cs_mag_s2),
		.sign_s2   (sign_s2)
	);

	lasc_track #(
		.RANGE_BITS     (RANGE_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ctl_s2    (ctl_s2),
		.range_s2  (range_s2),
		.sn_mag_s2 (sn_mag_s2),
		.cs_mag_s2 (cs_mag_s2),
		.sign_s2   (sign_s2),
		.res       (res)
	);

	lasc_oq u_oq (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.count  (q_count),
		.out_ch (clearance)
	);

endmodule
